// ===== design/block_header_checksum_macros.svh =====
// assertion macros shared by the checksum block modules
`ifndef BLOCK_HEADER_CHECKSUM_MACROS_SVH
`define BLOCK_HEADER_CHECKSUM_MACROS_SVH

// property checked on every clock edge outside reset
`define BHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define BHC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== design/bhc_pkg.sv =====
// types, constants and the crc byte update for the block header checksum
package bhc_pkg;

  localparam int unsigned PosW    = 5;
  localparam int unsigned CrcW    = 16;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'h0000;

  typedef struct packed {
    logic [15:0] crc_value;
    logic [7:0]  check_byte;
  } bhc_result_t;

  // msb-first crc-16-ccitt over one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/bhc_accum.sv =====
// header position, header xor and body crc state with the block result
`include "block_header_checksum_macros.svh"

module bhc_accum import bhc_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned XOR_BYTES    = 19,
  parameter int unsigned CRC_OFFSET   = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output bhc_result_t result_o
);

  localparam logic [PosW-1:0] HdrPos  = PosW'(HEADER_BYTES);
  localparam logic [PosW-1:0] XorPos  = PosW'(XOR_BYTES);
  localparam logic [PosW-1:0] CrcHiPos = PosW'(CRC_OFFSET);
  localparam logic [PosW-1:0] CrcLoPos = PosW'(CRC_OFFSET + 1);
  localparam bit FoldHi = (CRC_OFFSET < XOR_BYTES);
  localparam bit FoldLo = (CRC_OFFSET + 1 < XOR_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      xor_q, xor_d;
  logic            in_header;

  always_comb begin
    in_header = (pos_q < HdrPos);
    pos_d     = pos_q;
    crc_d     = crc_q;
    xor_d     = xor_q;
    if (in_header) begin
      if ((pos_q < XorPos) && (pos_q != CrcHiPos) && (pos_q != CrcLoPos)) begin
        xor_d = xor_q ^ byte_i;
      end
      pos_d = pos_q + PosW'(1);
    end else begin
      crc_d = crc16_byte(crc_q, byte_i);
    end

    // fold in the new crc bytes where the big-endian field sits in the xor range
    result_o.crc_value  = crc_d;
    result_o.check_byte = xor_d ^ (FoldHi ? crc_d[15:8] : 8'h00)
                                ^ (FoldLo ? crc_d[7:0]  : 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CrcInit;
      xor_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q <= '0;
        crc_q <= CrcInit;
        xor_q <= '0;
      end else begin
        pos_q <= pos_d;
        crc_q <= crc_d;
        xor_q <= xor_d;
      end
    end
  end

  `BHC_NEVER(a_pos_saturates, pos_q > HdrPos, "byte position ran past header length")
  `BHC_ASSERT(a_crc_idle_in_header, (pos_q < HdrPos) |-> (crc_q == CrcInit),
              "crc moved while still in header")
  `BHC_ASSERT(a_clear_after_last, (step_i && last_i) |=> (pos_q == '0 && crc_q == CrcInit
              && xor_q == '0), "state not cleared after final word")

endmodule

// ===== design/block_header_checksum.sv =====
// Block header checksum, top level.
// Takes one byte of a filesystem block per word on the slave stream, header first, with
// tlast on the final byte, and returns one result word per block: the CRC-16-CCITT
// (poly 0x1021, msb first, start 0) of the bytes after the header, and the XOR of the first
// XOR_BYTES header bytes with the new CRC placed big-endian at CRC_OFFSET. The stored CRC
// bytes of the incoming header are ignored. A byte is taken every cycle unless a final byte
// waits for room in a stalled result register; the result passes the input register, then
// the result register, and the bytewise CRC update between them sets the clock rate. A
// stalled result holds back only the next block's final byte, never the bytes before it.
`include "block_header_checksum_macros.svh"

module block_header_checksum import bhc_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned XOR_BYTES    = 19,
  parameter int unsigned CRC_OFFSET   = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] crc_value, [23:16] check_byte
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q;
  bhc_result_t out_q;
  bhc_result_t result;
  logic        step;
  logic        out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  // a final word needs room in the result register, other words always move on
  assign step          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  bhc_accum #(
    .HEADER_BYTES(HEADER_BYTES),
    .XOR_BYTES   (XOR_BYTES),
    .CRC_OFFSET  (CRC_OFFSET)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && in_last_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.check_byte, out_q.crc_value};

  `BHC_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(in_valid_q && in_last_q),
              "result appeared without a final word")
  `BHC_ASSERT(a_last_held, (in_valid_q && in_last_q && out_valid_q && !m_axis_tready)
              |=> (in_valid_q && in_last_q), "final word dropped while result stalled")
  `BHC_ASSERT(a_body_flows, (in_valid_q && !in_last_q) |-> s_axis_tready,
              "non-final word blocked the input")

endmodule
